// ===== hdl/sld_pkg.sv =====
// Package for the sync/length deframer: widths, event codes, phase encoding.
package sld_pkg;

    localparam int MAX_PAYLOAD = 512;
    localparam int LEN_W       = $clog2(MAX_PAYLOAD + 1);

    localparam int BYTE_W   = 8;
    localparam int POS_W    = 9;
    localparam int FLEN_W   = 10;
    localparam int CNT_W    = 32;
    localparam int KIND_W   = 2;
    localparam int CFG_IDX_W = 8;

    localparam int OUT_FIELDS_W = BYTE_W + POS_W + FLEN_W + 2 * CNT_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_PAD_W    = OUT_TDATA_W - OUT_FIELDS_W;

    localparam logic [BYTE_W-1:0] FIRST_SYNC_RST  = 8'h94;
    localparam logic [BYTE_W-1:0] SECOND_SYNC_RST = 8'hC3;

    localparam logic [CFG_IDX_W-1:0] REG_FIRST_SYNC  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SECOND_SYNC = 8'd1;

    localparam logic [KIND_W-1:0] EV_PAYLOAD = 2'd0;
    localparam logic [KIND_W-1:0] EV_EMPTY   = 2'd1;
    localparam logic [KIND_W-1:0] EV_SYNCERR = 2'd2;

    localparam logic ACT_BYTE   = 1'b0;
    localparam logic ACT_RESYNC = 1'b1;

    typedef enum logic [4:0] {
        PH_HUNT0 = 5'b00001,
        PH_HUNT1 = 5'b00010,
        PH_LENHI = 5'b00100,
        PH_LENLO = 5'b01000,
        PH_DATA  = 5'b10000
    } phase_t;

endpackage

// ===== hdl/sync_length_frame_deframer.sv =====
// Streaming deframer: two-byte sync hunt, 16-bit big-endian length, payload out.
// Output: a result is registered and appears on the master side in the cycle after its input transfer.
// Throughput: one input byte per cycle; the input is stalled only while a held
// result waits on m_axis_tready (output register).
// Reset: asynchronous, active low; returns to hunting for the first sync byte,
// clears both counters and loads the sync registers with 0x94 / 0xC3.
module sync_length_frame_deframer (
    input  logic                             clk,
    input  logic                             rst_n,
    // config write channel
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [sld_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [sld_pkg::BYTE_W-1:0]       cfg_data,
    // input stream
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [sld_pkg::BYTE_W-1:0]       s_axis_tdata,  // [7:0] rx_byte
    input  logic                             s_axis_tuser,  // [0] action
    // result stream
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [7:0] payload_byte, [16:8] byte_position, [26:17] frame_length,
    // [58:27] frames_total, [90:59] sync_errors_total, [95:91] zero
    output logic [sld_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    output logic [sld_pkg::KIND_W-1:0]       m_axis_tuser,  // [1:0] event_kind
    output logic                             m_axis_tlast   // last_byte
);
    import sld_pkg::*;

    logic [BYTE_W-1:0] first_sync_reg, second_sync_reg;
    phase_t            phase_reg, phase_next;
    logic [BYTE_W-1:0] len_hi_reg, len_hi_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [LEN_W-1:0]  idx_reg, idx_next;
    logic [CNT_W-1:0]  frame_cnt_reg, frame_cnt_next;
    logic [CNT_W-1:0]  err_cnt_reg, err_cnt_next;

    logic              out_valid_reg, out_valid_next;
    logic [KIND_W-1:0] kind_reg, kind_next;
    logic [BYTE_W-1:0] byte_reg, byte_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [FLEN_W-1:0] flen_reg, flen_next;
    logic              last_reg, last_next;

    logic              in_xfer;
    logic              emit;
    logic [15:0]       full_len;
    logic [LEN_W:0]    idx_plus;
    logic              is_last;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;

    assign full_len = {len_hi_reg, s_axis_tdata};
    assign idx_plus = {1'b0, idx_reg} + {{LEN_W{1'b0}}, 1'b1};
    assign is_last  = idx_plus >= {1'b0, len_reg};

    always_comb
    begin
        phase_next     = phase_reg;
        len_hi_next    = len_hi_reg;
        len_next       = len_reg;
        idx_next       = idx_reg;
        frame_cnt_next = frame_cnt_reg;
        err_cnt_next   = err_cnt_reg;
        emit           = 1'b0;
        kind_next      = EV_PAYLOAD;
        byte_next      = '0;
        pos_next       = '0;
        flen_next      = '0;
        last_next      = 1'b0;

        if (s_axis_tuser == ACT_RESYNC)
        begin
            phase_next = PH_HUNT0;
            len_hi_next = '0;
            len_next   = '0;
            idx_next   = '0;
        end
        else
        begin
            case (phase_reg)
                PH_HUNT0:
                begin
                    if (s_axis_tdata == first_sync_reg)
                        phase_next = PH_HUNT1;
                end
                PH_HUNT1:
                begin
                    // second sync match wins even if the byte also matches the first
                    if (s_axis_tdata == second_sync_reg)
                        phase_next = PH_LENHI;
                    else if (s_axis_tdata != first_sync_reg)
                    begin
                        phase_next = PH_HUNT0;
                        err_cnt_next = (&err_cnt_reg) ? err_cnt_reg : err_cnt_reg + 1'b1;
                        emit       = 1'b1;
                        kind_next  = EV_SYNCERR;
                    end
                end
                PH_LENHI:
                begin
                    len_hi_next = s_axis_tdata;
                    phase_next  = PH_LENLO;
                end
                PH_LENLO:
                begin
                    idx_next = '0;
                    if (full_len == 16'd0)
                    begin
                        len_next   = '0;
                        phase_next = PH_HUNT0;
                        emit       = 1'b1;
                        kind_next  = EV_EMPTY;
                    end
                    else if (full_len > 16'(MAX_PAYLOAD))
                    begin
                        len_next   = full_len[LEN_W-1:0];
                        phase_next = PH_HUNT0;
                        err_cnt_next = (&err_cnt_reg) ? err_cnt_reg : err_cnt_reg + 1'b1;
                        emit       = 1'b1;
                        kind_next  = EV_SYNCERR;
                    end
                    else
                    begin
                        len_next   = full_len[LEN_W-1:0];
                        phase_next = PH_DATA;
                    end
                end
                PH_DATA:
                begin
                    idx_next  = idx_plus[LEN_W-1:0];
                    emit      = 1'b1;
                    kind_next = EV_PAYLOAD;
                    byte_next = s_axis_tdata;
                    pos_next  = idx_reg[POS_W-1:0];
                    flen_next = FLEN_W'(len_reg);
                    last_next = is_last;
                    if (is_last)
                    begin
                        frame_cnt_next = (&frame_cnt_reg) ? frame_cnt_reg
                                                          : frame_cnt_reg + 1'b1;
                        phase_next = PH_HUNT0;
                    end
                end
                default:
                begin
                    phase_next = PH_HUNT0;
                    len_next   = '0;
                    idx_next   = '0;
                end
            endcase
        end
    end

    always_comb
    begin
        if (in_xfer && emit)
            out_valid_next = 1'b1;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_sync_reg  <= FIRST_SYNC_RST;
            second_sync_reg <= SECOND_SYNC_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == REG_FIRST_SYNC)
                first_sync_reg <= cfg_data;
            else if (cfg_index == REG_SECOND_SYNC)
                second_sync_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HUNT0;
            len_hi_reg    <= '0;
            len_reg       <= '0;
            idx_reg       <= '0;
            frame_cnt_reg <= '0;
            err_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (in_xfer)
            begin
                phase_reg     <= phase_next;
                len_hi_reg    <= len_hi_next;
                len_reg       <= len_next;
                idx_reg       <= idx_next;
                frame_cnt_reg <= frame_cnt_next;
                err_cnt_reg   <= err_cnt_next;
            end
        end
    end

    // result payload, loaded only with a new event
    always_ff @(posedge clk)
    begin
        if (in_xfer && emit)
        begin
            kind_reg <= kind_next;
            byte_reg <= byte_next;
            pos_reg  <= pos_next;
            flen_reg <= flen_next;
            last_reg <= last_next;
        end
    end

    logic [CNT_W-1:0] frames_out_reg, errors_out_reg;

    // counter snapshot taken with the event, after this transfer's update
    always_ff @(posedge clk)
    begin
        if (in_xfer && emit)
        begin
            frames_out_reg <= frame_cnt_next;
            errors_out_reg <= err_cnt_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = kind_reg;
    assign m_axis_tlast  = last_reg;
    assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, errors_out_reg, frames_out_reg,
                            flen_reg, pos_reg, byte_reg};

    // payload phase only ever holds a legal declared length
    a_len_legal: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_DATA) |-> (len_reg != '0 && len_reg <= LEN_W'(MAX_PAYLOAD)))
        else $error("payload phase with illegal length");

    a_pos_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser == EV_PAYLOAD) |-> ({1'b0, pos_reg} < flen_reg))
        else $error("byte position beyond frame length");

    a_last_payload: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tlast) |-> (m_axis_tuser == EV_PAYLOAD))
        else $error("last mark on a non-payload event");

    a_frames_mono: assert property (@(posedge clk) disable iff (!rst_n)
        ##1 (frame_cnt_reg >= $past(frame_cnt_reg) && err_cnt_reg >= $past(err_cnt_reg)))
        else $error("event counter decreased");

endmodule

// ===== verif/testbench.sv =====
// Testbench for sync_length_frame_deframer: stream driver, predictor and result checker.
`timescale 1ns / 100ps

module testbench;
    import sld_pkg::*;

    localparam int POS_LSB  = BYTE_W;
    localparam int FLEN_LSB = POS_LSB + POS_W;
    localparam int FRM_LSB  = FLEN_LSB + FLEN_W;
    localparam int ERR_LSB  = FRM_LSB + CNT_W;
    localparam int DRAIN_LIMIT = 2000;
    localparam int PRINT_LIMIT = 50;

    typedef struct {
        logic              act;
        logic [BYTE_W-1:0] rx_byte;
    } rx_item_t;

    typedef struct {
        logic [KIND_W-1:0] kind;
        logic [BYTE_W-1:0] data;
        logic [POS_W-1:0]  pos;
        logic [FLEN_W-1:0] flen;
        logic              last;
        logic [CNT_W-1:0]  frames;
        logic [CNT_W-1:0]  errors;
    } deframe_event_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [BYTE_W-1:0]      cfg_data = '0;

    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [BYTE_W-1:0]      s_axis_tdata = '0;   // [7:0] rx_byte
    logic                   s_axis_tuser = 1'b0; // [0] action

    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // [7:0] payload_byte, [16:8] byte_position, [26:17] frame_length,
    // [58:27] frames_total, [90:59] sync_errors_total, [95:91] zero
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic [KIND_W-1:0]      m_axis_tuser;        // [1:0] event_kind
    logic                   m_axis_tlast;        // last_byte

    sync_length_frame_deframer i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #4 clk = ~clk;

    // predictor state and its copy of the sync registers
    logic [BYTE_W-1:0] sync_first  = FIRST_SYNC_RST;
    logic [BYTE_W-1:0] sync_second = SECOND_SYNC_RST;
    phase_t            parse_ph    = PH_HUNT0;
    logic [15:0]       decl_len    = '0;
    logic [9:0]        pay_idx     = '0;
    logic [CNT_W-1:0]  frame_cnt   = '0;
    logic [CNT_W-1:0]  err_cnt     = '0;

    rx_item_t       rx_stream[$];
    deframe_event_t expected_events[$];
    rx_item_t       head;
    deframe_event_t want;
    deframe_event_t next_ev;

    int in_gap = 0;
    int in_mode = 1;
    int out_hold = 0;
    int out_mode = 1;
    int mismatches = 0;
    int bytes_in = 0;
    int results_seen = 0;
    int payload_seen = 0;
    int empty_seen = 0;
    int syncerr_seen = 0;
    int settings_seen = 1;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    function automatic bit deframe_step(input logic act, input logic [BYTE_W-1:0] b,
                                        output deframe_event_t ev);
        bit fire;
        fire = 1'b0;
        ev = '{default: '0};
        if (act == ACT_RESYNC) begin
            parse_ph = PH_HUNT0;
            decl_len = '0;
            pay_idx  = '0;
            return 1'b0;
        end
        case (parse_ph)
            PH_HUNT0:
                if (b == sync_first)
                    parse_ph = PH_HUNT1;
            PH_HUNT1:
                // second sync byte wins over a repeated first byte
                if (b == sync_second)
                    parse_ph = PH_LENHI;
                else if (b != sync_first) begin
                    err_cnt  = sat_inc(err_cnt);
                    parse_ph = PH_HUNT0;
                    ev.kind  = EV_SYNCERR;
                    fire     = 1'b1;
                end
            PH_LENHI:
            begin
                decl_len = {b, 8'h00};
                parse_ph = PH_LENLO;
            end
            PH_LENLO:
            begin
                decl_len[7:0] = b;
                pay_idx = '0;
                parse_ph = PH_HUNT0;
                fire = 1'b1;
                if (decl_len == 0)
                    ev.kind = EV_EMPTY;
                else if (int'(decl_len) > MAX_PAYLOAD) begin
                    err_cnt = sat_inc(err_cnt);
                    ev.kind = EV_SYNCERR;
                end
                else begin
                    parse_ph = PH_DATA;
                    fire = 1'b0;
                end
            end
            PH_DATA:
            begin
                ev.kind = EV_PAYLOAD;
                ev.data = b;
                ev.pos  = pay_idx[POS_W-1:0];
                ev.flen = decl_len[FLEN_W-1:0];
                ev.last = (int'(pay_idx) + 1 >= int'(decl_len));
                pay_idx = pay_idx + 1'b1;
                if (ev.last) begin
                    frame_cnt = sat_inc(frame_cnt);
                    parse_ph  = PH_HUNT0;
                end
                fire = 1'b1;
            end
            default:
            begin
                parse_ph = PH_HUNT0;
                decl_len = '0;
                pay_idx  = '0;
            end
        endcase
        ev.frames = frame_cnt;
        ev.errors = err_cnt;
        return fire;
    endfunction

    // mostly short gaps, now and then a long one; mode 0 gives no idling at all
    function automatic int pick_gap(input int mode);
        case (mode)
            0: return 0;
            1: return ($urandom_range(0, 2) == 0) ? int'($urandom_range(1, 3)) : 0;
            default: return ($urandom_range(0, 7) == 0) ? int'($urandom_range(8, 30))
                                                        : int'($urandom_range(0, 2));
        endcase
    endfunction

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= PRINT_LIMIT)
            $display("[%0t] ERROR %s", $time, msg);
    endtask

    task automatic compare_field(input string what, input logic [CNT_W-1:0] got,
                                 input logic [CNT_W-1:0] exp_val);
        if (got !== exp_val)
            report_mismatch($sformatf("%s: got 0x%0h, want 0x%0h", what, got, exp_val));
    endtask

    // input stream driver
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            s_axis_tvalid <= 1'b0;
            in_gap <= 0;
        end
        else if (!s_axis_tvalid || s_axis_tready) begin
            if (in_gap > 0) begin
                s_axis_tvalid <= 1'b0;
                in_gap <= in_gap - 1;
            end
            else if (rx_stream.size() != 0) begin
                head = rx_stream.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= head.rx_byte;
                s_axis_tuser  <= head.act;
                in_gap <= pick_gap(in_mode);
                if ($urandom_range(0, 49) == 0)
                    in_mode <= $urandom_range(0, 2);
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // result side backpressure
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            m_axis_tready <= 1'b0;
            out_hold <= 0;
        end
        else if (out_hold > 0) begin
            m_axis_tready <= 1'b0;
            out_hold <= out_hold - 1;
        end
        else begin
            m_axis_tready <= 1'b1;
            if (m_axis_tvalid && m_axis_tready) begin
                out_hold <= pick_gap(out_mode);
                if ($urandom_range(0, 39) == 0)
                    out_mode <= $urandom_range(0, 2);
            end
        end
    end

    // monitor: predict on every input transfer, check every result transfer
    always @(posedge clk) begin
        if (rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                bytes_in++;
                if (deframe_step(s_axis_tuser, s_axis_tdata, next_ev))
                    expected_events.push_back(next_ev);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                results_seen++;
                if (expected_events.size() == 0)
                    report_mismatch($sformatf("result with nothing expected, kind %0d",
                                              m_axis_tuser));
                else begin
                    want = expected_events.pop_front();
                    case (want.kind)
                        EV_PAYLOAD: payload_seen++;
                        EV_EMPTY:   empty_seen++;
                        default:    syncerr_seen++;
                    endcase
                    compare_field("event_kind", CNT_W'(m_axis_tuser), CNT_W'(want.kind));
                    compare_field("payload_byte", CNT_W'(m_axis_tdata[POS_LSB-1:0]),
                                  CNT_W'(want.data));
                    compare_field("byte_position",
                                  CNT_W'(m_axis_tdata[FLEN_LSB-1:POS_LSB]),
                                  CNT_W'(want.pos));
                    compare_field("frame_length",
                                  CNT_W'(m_axis_tdata[FRM_LSB-1:FLEN_LSB]),
                                  CNT_W'(want.flen));
                    compare_field("last_byte", CNT_W'(m_axis_tlast), CNT_W'(want.last));
                    compare_field("frames_total", m_axis_tdata[ERR_LSB-1:FRM_LSB],
                                  want.frames);
                    compare_field("sync_errors_total", m_axis_tdata[ERR_LSB+CNT_W-1:ERR_LSB],
                                  want.errors);
                    compare_field("tdata padding", CNT_W'(m_axis_tdata >> OUT_FIELDS_W),
                                  '0);
                end
            end
        end
    end

    function automatic void push_byte(input logic [BYTE_W-1:0] b);
        rx_stream.push_back('{ACT_BYTE, b});
    endfunction

    function automatic void push_resync();
        // the byte lane carries noise, the block must ignore it
        rx_stream.push_back('{ACT_RESYNC, BYTE_W'($urandom_range(0, 255))});
    endfunction

    function automatic void push_header(input logic [15:0] len);
        push_byte(sync_first);
        push_byte(sync_second);
        push_byte(len[15:8]);
        push_byte(len[7:0]);
    endfunction

    function automatic void push_frame(input int len);
        push_header(16'(len));
        for (int i = 0; i < len; i++)
            push_byte(BYTE_W'($urandom_range(0, 255)));
    endfunction

    function automatic logic [BYTE_W-1:0] bad_second();
        logic [BYTE_W-1:0] b;
        do
            b = BYTE_W'($urandom_range(0, 255));
        while (b == sync_second || b == sync_first);
        return b;
    endfunction

    function automatic void push_traffic(input int count);
        int target;
        int pick;
        int len;
        int cut;
        target = rx_stream.size() + count;
        while (rx_stream.size() < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 68) begin
                len = $urandom_range(0, 19);
                if (len == 0)
                    push_frame(0);
                else if (len < 18)
                    push_frame($urandom_range(1, 12));
                else
                    push_frame($urandom_range(13, 64));
            end
            else if (pick < 76) begin
                repeat ($urandom_range(1, 3))
                    push_byte(BYTE_W'($urandom_range(0, 255)));
            end
            else if (pick < 82) begin
                push_byte(sync_first);
                push_byte(bad_second());
            end
            else if (pick < 88)
                push_header(16'($urandom_range(MAX_PAYLOAD + 1, 65535)));
            else if (pick < 95) begin
                // resync at a random point of a frame
                cut = $urandom_range(0, 4);
                len = $urandom_range(2, 10);
                push_byte(sync_first);
                if (cut >= 1)
                    push_byte(sync_second);
                if (cut >= 2)
                    push_byte(8'h00);
                if (cut >= 3)
                    push_byte(8'(len));
                if (cut == 4)
                    repeat ($urandom_range(1, len - 1))
                        push_byte(BYTE_W'($urandom_range(0, 255)));
                push_resync();
            end
            else begin
                repeat ($urandom_range(1, 3))
                    push_byte(sync_first);
                push_frame($urandom_range(1, 6));
            end
        end
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == REG_FIRST_SYNC)
            sync_first = val;
        else if (idx == REG_SECOND_SYNC)
            sync_second = val;
    endtask

    task automatic set_sync(input logic [BYTE_W-1:0] first, input logic [BYTE_W-1:0] second);
        write_reg(REG_FIRST_SYNC, first);
        write_reg(REG_SECOND_SYNC, second);
        settings_seen++;
        @(negedge clk);
    endtask

    // wait until all input is taken and every expected result is in
    task automatic settle();
        int waited;
        waited = 0;
        while (rx_stream.size() != 0 || s_axis_tvalid)
            @(posedge clk);
        while (expected_events.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge clk);
            waited++;
        end
        repeat (4) @(posedge clk);
        if (expected_events.size() != 0) begin
            report_mismatch($sformatf("%0d expected results never arrived",
                                      expected_events.size()));
            expected_events.delete();
        end
    endtask

    initial begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: stray bytes, repeated first sync, empty, wrong second, oversize
        push_byte(8'h00);
        push_byte(8'hFF);
        push_byte(sync_first);
        push_byte(sync_first);
        push_byte(sync_second);
        push_byte(8'h00);
        push_byte(8'h00);
        push_byte(sync_first);
        push_byte(8'h00);
        push_header(16'(MAX_PAYLOAD + 1));
        push_header(16'hFFFF);
        push_header(16'd2);
        push_byte(8'hFF);
        push_byte(8'h00);
        push_header(16'd3);
        push_byte(8'h5A);
        push_resync();
        push_frame(1);
        push_traffic(30);
        // largest legal length, cut short by a resync once positions pass 256
        push_header(16'(MAX_PAYLOAD));
        repeat (300)
            push_byte(BYTE_W'($urandom_range(0, 255)));
        push_resync();
        push_frame(1);
        settle();

        // index outside the register list must change nothing
        write_reg(CFG_IDX_W'($urandom_range(REG_SECOND_SYNC + 1, 255)), 8'h00);
        set_sync(8'h00, 8'hFF);
        push_traffic(20);
        settle();

        set_sync(8'hFF, 8'h00);
        push_traffic(20);
        settle();

        // equal sync bytes: the second copy is taken as the second sync byte
        set_sync(8'h5A, 8'h5A);
        push_byte(8'h5A);
        push_byte(8'h5A);
        push_byte(8'h5A);
        push_byte(8'h5A);
        push_byte(8'h00);
        push_byte(8'h02);
        push_byte(8'h11);
        push_byte(8'h22);
        push_traffic(20);
        settle();

        repeat (2) begin
            set_sync(BYTE_W'($urandom_range(0, 255)), BYTE_W'($urandom_range(0, 255)));
            push_traffic(20);
            settle();
        end

        set_sync(FIRST_SYNC_RST, SECOND_SYNC_RST);
        push_traffic(15);
        settle();

        $display("Run covered %0d input bytes over %0d sync settings.", bytes_in,
                 settings_seen);
        $display("Checked %0d results: %0d payload, %0d empty frames, %0d sync errors.",
                 results_seen, payload_seen, empty_seen, syncerr_seen);
        if (mismatches == 0)
            $display("sync_length_frame_deframer: match");
        else
            $display("sync_length_frame_deframer: mismatch");
        $finish;
    end

    initial begin
        #5ms;
        $display("Timeout with %0d results still expected.", expected_events.size());
        $display("sync_length_frame_deframer: mismatch");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/sld_pkg.sv
hdl/sync_length_frame_deframer.sv
verif/testbench.sv
